// ===== hdl/dpfsm_pkg.sv =====
// Shared types for the distinct prime factor sum unit: controller states and control links.
package dpfsm_pkg;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // capture a new item, restart the factoring
    logic div_start;  // launch one remainder/quotient computation
    logic step;       // apply the division result to n, d and the sum
    logic out_load;   // move the finished sum into the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic below_two;  // remaining n is below 2
    logic div_done;   // division result is ready
    logic stop;       // trial divisor has passed the square root of n
    logic out_free;   // output register can take a new result
  } sts_t;

endpackage

// ===== hdl/dpfsm_div.sv =====
// Restoring divider producing one quotient bit per cycle.
module dpfsm_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  dsr;
  logic [W:0]    shifted;
  logic [W:0]    trial;

  // Shift in the next dividend bit and try a subtraction
  assign shifted = {rem, quo[W-1]};
  assign trial   = shifted - {1'b0, dsr};

  // Control: count the steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: keep the partial remainder, build the quotient in place
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= shifted[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== hdl/dpfsm_dp.sv =====
// Datapath: remaining value, trial divisor, factor sum, group maximum and output register.
module dpfsm_dp
  import dpfsm_pkg::*;
#(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         cmd,
  output sts_t         sts,
  input  logic [W-1:0] value,
  input  logic         group_end,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] factor_sum,
  output logic [W-1:0] group_max
);

  logic [W-1:0] n;
  logic [W-1:0] d;
  logic [W-1:0] total;
  logic         inner;
  logic         last;
  logic [W-1:0] running_max;
  logic [W-1:0] quo;
  logic [W-1:0] rem;
  logic         div_done;
  logic [W-1:0] sum_final;
  logic [W-1:0] max_next;

  dpfsm_div #(.W(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (n),
    .divisor  (d),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  // Status back to the controller
  assign sts.below_two = (n < W'(2));
  assign sts.div_done  = div_done;
  assign sts.stop      = !inner && (d > quo);
  assign sts.out_free  = !out_valid || out_ready;

  // Add what is left over once the divisor passes its square root
  assign sum_final = total + ((n > W'(1)) ? n : '0);
  assign max_next  = (sum_final > running_max) ? sum_final : running_max;

  // Factoring registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n     <= value;
      d     <= W'(2);
      total <= '0;
      inner <= 1'b0;
      last  <= group_end;
    end else if (cmd.step) begin
      if (inner) begin
        // keep dividing out the same prime
        if (rem == '0) begin
          n <= quo;
        end else begin
          d     <= d + 1'b1;
          inner <= 1'b0;
        end
      end else if (rem == '0) begin
        // new prime factor: count it once
        total <= total + d;
        n     <= quo;
        inner <= 1'b1;
      end else begin
        d <= d + 1'b1;
      end
    end
  end

  // Output register and group maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      running_max <= '0;
    end else begin
      if (cmd.out_load) begin
        out_valid   <= 1'b1;
        running_max <= last ? '0 : max_next;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      factor_sum <= sum_final;
      group_max  <= max_next;
    end
  end

endmodule

// ===== hdl/dpfsm_ctrl.sv =====
// Controller: sequences loading, trial divisions and result hand-off for one item.
module dpfsm_ctrl
  import dpfsm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts.below_two) begin
          state_next = ST_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          if (sts.stop) begin
            state_next = ST_OUT;
          end else begin
            cmd.step   = 1'b1;
            state_next = ST_LOAD;
          end
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/distinct_prime_factor_sum_max_unit.sv =====
// Top level of the distinct prime factor sum unit with running group maximum.
// Each accepted item is factored by trial division: the divisor starts at 2,
// divides out each prime it finds (counting that prime once in factor_sum)
// and stops once it exceeds the square root of what remains, which is then
// added if above 1. Every trial is one pass through a shared restoring
// divider, started from ST_LOAD and awaited in ST_DIV; the number of trials
// is about the larger of the second largest prime factor and the square root
// of the largest one, plus the count of prime factors with repeats.
// A 32-bit prime needs about 65536 trials; 0 and 1 skip the divider and go
// straight to the output. One item is worked on at a time. The result sits
// in an output register, so the next item is taken while it waits.
// group_max includes the current item; an item with group_end set clears the
// maximum after its result is formed.
module distinct_prime_factor_sum_max_unit
  import dpfsm_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic                   group_end,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] factor_sum,
  output logic [VALUE_WIDTH-1:0] group_max
);

  cmd_t cmd;
  sts_t sts;

  dpfsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dpfsm_dp #(.W(VALUE_WIDTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .value      (value),
    .group_end  (group_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .factor_sum (factor_sum),
    .group_max  (group_max)
  );

endmodule
